### hdl/rgb_to_lalphabeta_color_core_assert.svh
// ----------------------------------------------------------------------------
// rgb_to_lalphabeta_color_core assertion macros
// shared concurrent assertion forms, clocked on i_clk
// ----------------------------------------------------------------------------
`ifndef RGB_TO_LALPHABETA_COLOR_CORE_ASSERT_SVH
`define RGB_TO_LALPHABETA_COLOR_CORE_ASSERT_SVH

// same-cycle implication, masked while reset is asserted
`define RLAB_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rlab assertion failed");

// next-cycle implication, masked while reset is asserted
`define RLAB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rlab assertion failed");

// next-cycle implication that is checked through reset as well
`define RLAB_ASSERT_NEXT_ALWAYS(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("rlab assertion failed");

`endif

### hdl/rlab_pkg.sv
// ----------------------------------------------------------------------------
// rlab_pkg
// shared types and constants of the l-alpha-beta colour converter
// ----------------------------------------------------------------------------
`default_nettype none

package rlab_pkg;

    // cone response, integer scaled by 10000
    localparam int RESP_W  = 22;
    // log10 result, signed, 24 fraction bits
    localparam int LOGQ_W  = 30;
    // transform products
    localparam int PROD_W  = 52;
    localparam int FIELD_W = 16;

    typedef logic [RESP_W-1:0]         t_resp;
    typedef logic signed [LOGQ_W-1:0]  t_logq;
    typedef logic signed [PROD_W-1:0]  t_prod;
    typedef logic signed [FIELD_W-1:0] t_field;

endpackage

`default_nettype wire

### hdl/rlab_log10.sv
// ----------------------------------------------------------------------------
// rlab_log10
// pipelined base-10 logarithm of a cone response, one squaring per fraction-bit stage
// ----------------------------------------------------------------------------
`default_nettype none

module rlab_log10 (
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  wire rlab_pkg::t_resp i_x,
    output rlab_pkg::t_logq    o_lq
);
    import rlab_pkg::*;

    localparam int STEPS = 24;
    localparam logic [28:0] LOG10_2_Q30 = 29'd323228497;
    localparam logic [57:0] RND         = 58'd1 << 29;
    localparam t_logq       FOUR_Q24    = 30'sd67108864;

    logic [4:0]  n_msb;
    logic [31:0] n_mant;

    logic [31:0]      r_y [0:STEPS];
    logic [4:0]       r_n [0:STEPS];
    logic [STEPS-1:0] r_f [0:STEPS];
    logic [57:0]      r_p;
    t_logq            r_lq;

    // leading one search
    always_comb begin
        n_msb = 5'd0;
        for (int i = 0; i < RESP_W; i++) begin
            if (i_x[i]) begin
                n_msb = 5'(i);
            end
        end
        n_mant = {10'd0, i_x} << (5'd31 - n_msb);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_y[0] <= n_mant;
            r_n[0] <= n_msb;
            r_f[0] <= '0;
        end
    end

    // one fraction bit per stage by squaring the mantissa
    for (genvar k = 0; k < STEPS; k++) begin : g_sq
        logic [63:0] n_sq;
        logic [32:0] n_t;
        always_comb begin
            n_sq = 64'(r_y[k]) * 64'(r_y[k]);
            n_t  = n_sq[63:31];
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_y[k+1] <= n_t[32] ? n_t[32:1] : n_t[31:0];
                r_n[k+1] <= r_n[k];
                r_f[k+1] <= {r_f[k][STEPS-2:0], n_t[32]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p  <= 58'({r_n[STEPS], r_f[STEPS]}) * 58'(LOG10_2_Q30);
            r_lq <= $signed(LOGQ_W'((r_p + RND) >> 30)) - FOUR_Q24;
        end
    end

    assign o_lq = r_lq;

endmodule

`default_nettype wire

### hdl/rlab_fix.sv
// ----------------------------------------------------------------------------
// rlab_fix
// rounds a transform product to the output grid and saturates to 16 bits
// ----------------------------------------------------------------------------
`default_nettype none

module rlab_fix #(
    parameter int FRAC_BITS = 12
) (
    input  wire logic           i_clk,
    input  wire logic           i_en,
    input  wire rlab_pkg::t_prod i_p,
    output rlab_pkg::t_field    o_v
);
    import rlab_pkg::*;

    // divisor is 10^6 * 2^(24-FRAC_BITS) = 15625 * 2^(30-FRAC_BITS)
    localparam int    SH    = 30 - FRAC_BITS;
    localparam t_prod HALF  = 52'sd500000 <<< (24 - FRAC_BITS);
    localparam t_prod LIM   = 52'sd512000000;
    localparam logic [29:0] LIM_U = 30'd512000000;
    localparam logic [30:0] RECIP = 31'd1125899906;
    localparam logic [13:0] DIV   = 14'd15625;

    t_prod       n_q;
    logic [29:0] r_u1, r_u2;
    logic [1:0]  r_sat1, r_sat2;
    logic [16:0] r_qh;
    logic [60:0] n_prod;
    logic [30:0] n_rem;
    logic [16:0] n_quo;
    t_field      r_v;

    assign n_q = (i_p + HALF) >>> SH;

    // sat[1]: above range, sat[0]: below range
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sat1 <= {n_q >= LIM, n_q < -LIM};
            r_u1   <= n_q[29:0] + LIM_U;
        end
    end

    // quotient estimate, at most one short
    assign n_prod = 61'(r_u1) * 61'(RECIP);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_qh   <= n_prod[60:44];
            r_u2   <= r_u1;
            r_sat2 <= r_sat1;
        end
    end

    always_comb begin
        n_rem = 31'(r_u2) - (31'(r_qh) * 31'(DIV));
        n_quo = r_qh + 17'(n_rem >= 31'(DIV));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_sat2[1]) begin
                r_v <= 16'sh7fff;
            end else if (r_sat2[0]) begin
                r_v <= 16'sh8000;
            end else begin
                r_v <= {~n_quo[15], n_quo[14:0]};
            end
        end
    end

    assign o_v = r_v;

endmodule

`default_nettype wire

### hdl/rgb_to_lalphabeta_color_core.sv
// ----------------------------------------------------------------------------
// rgb_to_lalphabeta_color_core
// rgb pixel to ruderman l-alpha-beta colour, fully pipelined
// ----------------------------------------------------------------------------
// usage:
//   slave side takes one pixel per request: tdata = red, green, blue (8 bits
//   each, red lowest). master side gives one result per pixel: tdata =
//   lightness, alpha, beta (16-bit two's complement, FRAC_BITS fraction bits,
//   lightness lowest), in pixel order.
//   throughput is one pixel per clock while tready stays high. the path from
//   request to result has one stage for the cone sums, 27 for the logarithm
//   (24 of them one mantissa squaring each), two for the transform and three
//   for rounding and saturation.
//   the whole pipeline advances together; when the receiver holds tready low
//   with a result waiting, every stage holds and s_axis_tready falls, so
//   nothing is lost or repeated. bubbles travel as cleared valid bits.
//   reset clears all valid bits; payload registers are left as they are.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_to_lalphabeta_color_core #(
    parameter int FRAC_BITS = 12
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // red [7:0], green [15:8], blue [23:16]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata    // lightness [15:0], alpha [31:16], beta [47:32]
);
    import rlab_pkg::*;

    localparam int LAT = 33;

    localparam t_resp ZERO_SUB = 22'd20000;

    logic          w_en;
    logic [LAT-1:0] r_vld;

    t_resp n_l, n_m, n_s;
    t_resp r_l, r_m, r_s;
    t_logq w_lq, w_mq, w_sq;
    t_prod r_sl, r_sa, r_sb;
    t_prod r_pl, r_pa, r_pb;
    t_field w_lig, w_alp, w_bet;

    assign w_en          = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = w_en;
    assign m_axis_tvalid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], s_axis_tvalid};
        end
    end

    // cone responses scaled by 10000
    always_comb begin
        n_l = 22'(12'd3811 * 22'(s_axis_tdata[7:0])) + 22'(13'd5783 * 22'(s_axis_tdata[15:8]))
            + 22'(9'd402 * 22'(s_axis_tdata[23:16]));
        n_m = 22'(11'd1967 * 22'(s_axis_tdata[7:0])) + 22'(13'd7244 * 22'(s_axis_tdata[15:8]))
            + 22'(10'd782 * 22'(s_axis_tdata[23:16]));
        n_s = 22'(8'd241 * 22'(s_axis_tdata[7:0])) + 22'(11'd1288 * 22'(s_axis_tdata[15:8]))
            + 22'(14'd8444 * 22'(s_axis_tdata[23:16]));
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_l <= (n_l == '0) ? ZERO_SUB : n_l;
            r_m <= (n_m == '0) ? ZERO_SUB : n_m;
            r_s <= (n_s == '0) ? ZERO_SUB : n_s;
        end
    end

    rlab_log10 u_log_l (.i_clk(i_clk), .i_en(w_en), .i_x(r_l), .o_lq(w_lq));
    rlab_log10 u_log_m (.i_clk(i_clk), .i_en(w_en), .i_x(r_m), .o_lq(w_mq));
    rlab_log10 u_log_s (.i_clk(i_clk), .i_en(w_en), .i_x(r_s), .o_lq(w_sq));

    // alpha uses 816496 = 2 * 408248, so one product serves
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sl <= PROD_W'(w_lq) + PROD_W'(w_mq) + PROD_W'(w_sq);
            r_sa <= PROD_W'(w_lq) + PROD_W'(w_mq) - (PROD_W'(w_sq) <<< 1);
            r_sb <= PROD_W'(w_lq) - PROD_W'(w_mq);
            r_pl <= r_sl * 52'sd577350;
            r_pa <= r_sa * 52'sd408248;
            r_pb <= r_sb * 52'sd707107;
        end
    end

    rlab_fix #(.FRAC_BITS(FRAC_BITS)) u_fix_l (.i_clk(i_clk), .i_en(w_en), .i_p(r_pl), .o_v(w_lig));
    rlab_fix #(.FRAC_BITS(FRAC_BITS)) u_fix_a (.i_clk(i_clk), .i_en(w_en), .i_p(r_pa), .o_v(w_alp));
    rlab_fix #(.FRAC_BITS(FRAC_BITS)) u_fix_b (.i_clk(i_clk), .i_en(w_en), .i_p(r_pb), .o_v(w_bet));

    assign m_axis_tdata = {w_bet, w_alp, w_lig};

`include "rgb_to_lalphabeta_color_core_assert.svh"

    `RLAB_ASSERT_NOW(a_stall_blocks_input, m_axis_tvalid && !m_axis_tready, !s_axis_tready)
    `RLAB_ASSERT_NEXT(a_request_enters, s_axis_tvalid && s_axis_tready, r_vld[0])
    `RLAB_ASSERT_NEXT(a_held_result_stays, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `RLAB_ASSERT_NEXT_ALWAYS(a_reset_empties, !i_rst_n, !m_axis_tvalid && r_vld == '0)

endmodule

`default_nettype wire
